FILE: rtl/range_sum_point_update_tree_defines.svh
// Assertion macros for the range-sum tree.
`ifndef RANGE_SUM_POINT_UPDATE_TREE_DEFINES_SVH
`define RANGE_SUM_POINT_UPDATE_TREE_DEFINES_SVH

`ifndef SYNTHESIS
`define RSTU_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define RSTU_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define RSTU_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define RSTU_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: rtl/rstu_pkg.sv
package rstu_pkg;

	localparam int IDX_W = 10;
	localparam int VAL_W = 32;
	localparam int SUM_W = 42;

	typedef logic [SUM_W-1:0] sum_t;

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_QUERY = 1'b1
	} req_kind_t;

	// result handed from the sequencer to the output register
	typedef struct packed {
		logic valid;
		sum_t total;
	} res_t;

	function automatic sum_t sext_val(input logic signed [VAL_W-1:0] v);
		return SUM_W'(v);
	endfunction

endpackage

FILE: rtl/rstu_mem.sv
module rstu_mem #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  rstu_pkg::sum_t  wdata,
	input  logic [AW-1:0]   raddr0,
	input  logic [AW-1:0]   raddr1,
	output rstu_pkg::sum_t  rdata0,
	output rstu_pkg::sum_t  rdata1
);
	import rstu_pkg::*;

	sum_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

FILE: rtl/rstu_seq.sv
module rstu_seq #(
	parameter int NUM_ELEMS = 1024,
	parameter int AW        = 11
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              req_type,
	input  logic [rstu_pkg::IDX_W-1:0]        elem_index,
	input  logic signed [rstu_pkg::VAL_W-1:0] elem_value,
	input  logic [rstu_pkg::IDX_W-1:0]        range_start,
	input  logic [rstu_pkg::IDX_W-1:0]        range_end,
	output rstu_pkg::res_t                    res,
	input  logic                              res_ready,
	output logic                              we,
	output logic [AW-1:0]                     waddr,
	output rstu_pkg::sum_t                    wdata,
	output logic [AW-1:0]                     raddr0,
	output logic [AW-1:0]                     raddr1,
	input  rstu_pkg::sum_t                    rdata0,
	input  rstu_pkg::sum_t                    rdata1
);
	import rstu_pkg::*;

	// query bounds reach 2*NUM_ELEMS, one bit past the address range
	localparam int          PW   = AW + 1;
	localparam logic [31:0] N32  = 32'(NUM_ELEMS);
	localparam logic [AW-1:0] CLR_LAST = AW'(2 * NUM_ELEMS - 1);
	localparam logic [AW-1:0] ROOT     = AW'(1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD,
		ST_QRY,
		ST_DONE
	} state_t;

	state_t         state_q;
	logic [AW-1:0]  clr_q;
	logic           rv0_q;
	logic           rv1_q;
	logic [AW-1:0]  pos_q;
	sum_t           cur_q;
	logic [PW-1:0]  l_q;
	logic [PW-1:0]  r_q;
	sum_t           acc_q;

	logic           acc_wr;
	logic           acc_qry;
	logic [31:0]    idx32;
	logic [31:0]    lo32;
	logic [31:0]    hi32;
	logic [31:0]    hic32;
	logic           idx_ok;
	logic           q_empty;
	logic [AW-1:0]  leaf;
	logic [AW-1:0]  parent;
	sum_t           upd_sum;
	sum_t           acc_add;
	logic [PW-1:0]  l_nx;
	logic [PW-1:0]  r_nx;
	logic [PW-1:0]  r_m1;
	logic [PW-1:0]  l_init;
	logic [PW-1:0]  r_init;

	assign in_ready = (state_q == ST_IDLE);
	assign acc_wr   = in_valid && in_ready && (req_type == REQ_WRITE);
	assign acc_qry  = in_valid && in_ready && (req_type == REQ_QUERY);

	assign idx32   = 32'(elem_index);
	assign lo32    = 32'(range_start);
	assign hi32    = 32'(range_end);
	assign idx_ok  = idx32 < N32;
	assign q_empty = (lo32 > hi32) || (lo32 >= N32);
	assign hic32   = (hi32 >= N32) ? (N32 - 32'd1) : hi32;
	assign leaf    = AW'(idx32 + N32);
	assign l_init  = PW'(lo32 + N32);
	assign r_init  = PW'(hic32 + N32 + 32'd1);

	assign parent  = pos_q >> 1;
	assign upd_sum = cur_q + rdata0;

	assign l_nx    = l_q + PW'(l_q[0]);
	assign r_nx    = r_q - PW'(r_q[0]);
	assign r_m1    = r_q - PW'(1);
	assign acc_add = acc_q + (rv0_q ? rdata0 : '0) + (rv1_q ? rdata1 : '0);

	assign res.valid = (state_q == ST_DONE);
	assign res.total = acc_q;

	// memory port steering; the sibling of node p is p^1
	always_comb begin
		we     = 1'b0;
		waddr  = '0;
		wdata  = '0;
		raddr0 = '0;
		raddr1 = '0;
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			ST_IDLE: begin
				we     = acc_wr && idx_ok;
				waddr  = leaf;
				wdata  = sext_val(elem_value);
				raddr0 = {leaf[AW-1:1], ~leaf[0]};
			end
			ST_UPD: begin
				we     = 1'b1;
				waddr  = parent;
				wdata  = upd_sum;
				raddr0 = {parent[AW-1:1], ~parent[0]};
			end
			ST_QRY: begin
				raddr0 = l_q[AW-1:0];
				raddr1 = r_m1[AW-1:0];
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			rv0_q   <= 1'b0;
			rv1_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					rv0_q <= 1'b0;
					rv1_q <= 1'b0;
					if (acc_wr && idx_ok) begin
						state_q <= ST_UPD;
					end else if (acc_qry) begin
						state_q <= q_empty ? ST_DONE : ST_QRY;
					end
				end
				ST_UPD: begin
					if (parent == ROOT) begin
						state_q <= ST_IDLE;
					end
				end
				ST_QRY: begin
					if (l_q < r_q) begin
						rv0_q <= l_q[0];
						rv1_q <= r_q[0];
					end else begin
						rv0_q   <= 1'b0;
						rv1_q   <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				pos_q <= leaf;
				cur_q <= sext_val(elem_value);
				l_q   <= l_init;
				r_q   <= r_init;
				acc_q <= '0;
			end
			ST_UPD: begin
				pos_q <= parent;
				cur_q <= upd_sum;
			end
			ST_QRY: begin
				acc_q <= acc_add;
				l_q   <= l_nx >> 1;
				r_q   <= r_nx >> 1;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/range_sum_point_update_tree.sv
// Range-sum tree with point update over NUM_ELEMS signed 32-bit elements. Partial sums live in
// one 2*NUM_ELEMS-entry memory (two read ports, one write port, registered reads) laid out as an
// implicit tree: root at 1, children of p at 2p and 2p+1, leaves from NUM_ELEMS up. After reset
// in_ready stays low for a clearing pass over all 2*NUM_ELEMS entries. One item is worked at
// a time and each tree level costs one memory access: a write walks leaf to root and returns
// nothing; a query walks both bounds upward until they meet, and then its result reaches the
// output register. Writes at or past NUM_ELEMS are dropped; query bounds are clipped to the
// array, and an empty range returns zero. The output register lets the next item be taken
// while a result waits.
`include "range_sum_point_update_tree_defines.svh"

module range_sum_point_update_tree #(
	parameter int NUM_ELEMS = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              req_type,
	input  logic [rstu_pkg::IDX_W-1:0]        elem_index,
	input  logic signed [rstu_pkg::VAL_W-1:0] elem_value,
	input  logic [rstu_pkg::IDX_W-1:0]        range_start,
	input  logic [rstu_pkg::IDX_W-1:0]        range_end,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [rstu_pkg::SUM_W-1:0] range_total
);
	import rstu_pkg::*;

	localparam int DEPTH = 2 * NUM_ELEMS;
	localparam int AW    = $clog2(DEPTH);

	res_t          res;
	logic          res_ready;
	logic          we;
	logic [AW-1:0] waddr;
	sum_t          wdata;
	logic [AW-1:0] raddr0;
	logic [AW-1:0] raddr1;
	sum_t          rdata0;
	sum_t          rdata1;
	logic          out_valid_q;
	sum_t          total_q;
	logic          wr_take;
	logic          qry_take;

	rstu_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	rstu_seq #(
		.NUM_ELEMS (NUM_ELEMS),
		.AW        (AW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.elem_index  (elem_index),
		.elem_value  (elem_value),
		.range_start (range_start),
		.range_end   (range_end),
		.res         (res),
		.res_ready   (res_ready),
		.we          (we),
		.waddr       (waddr),
		.wdata       (wdata),
		.raddr0      (raddr0),
		.raddr1      (raddr1),
		.rdata0      (rdata0),
		.rdata1      (rdata1)
	);

	// output register: refilled in the cycle its transfer completes
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			total_q <= res.total;
		end
	end

	assign out_valid   = out_valid_q;
	assign range_total = total_q;

	assign qry_take = in_valid && in_ready && (req_type == REQ_QUERY);
	assign wr_take  = in_valid && in_ready && (req_type == REQ_WRITE)
		&& (32'(elem_index) < 32'(NUM_ELEMS));

	`RSTU_ASSERT_IMP(a_res_not_idle, clk, arst_n, res.valid, !in_ready, "result while idle")
	`RSTU_ASSERT_NXT(a_qry_busy, clk, arst_n, qry_take, !in_ready, "query not taken up")
	`RSTU_ASSERT_NXT(a_wr_busy, clk, arst_n, wr_take, !in_ready && !res.valid, "write walk idle")

endmodule

FILE: tb/sv/tb_range_sum_point_update_tree.sv
module tb_range_sum_point_update_tree;

	import rstu_pkg::*;

	localparam int ELEMS = 1024;
	localparam int TOP   = ELEMS - 1;

	typedef logic [63:0] wide_sum_t;

	// Mirror of the partial-sum tree plus the totals still owed by the block.
	class range_sum_scoreboard;
		wide_sum_t  tree_sums[2*ELEMS];
		sum_t       pending_totals[$];
		int         errors;
		int         writes;
		int         queries;
		int         empty_queries;
		int         totals_checked;

		function new();
			foreach (tree_sums[n])
				tree_sums[n] = '0;
			errors = 0;
			writes = 0;
			queries = 0;
			empty_queries = 0;
			totals_checked = 0;
		endfunction

		function void note_request(input logic kind, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] val, input logic [IDX_W-1:0] lo_pos,
			input logic [IDX_W-1:0] hi_pos);
			int unsigned p;
			int unsigned l;
			int unsigned r;
			int unsigned hi_c;
			wide_sum_t   acc;
			if (kind == REQ_WRITE) begin
				writes++;
				if (int'(idx) >= ELEMS)
					return;
				p = idx + ELEMS;
				tree_sums[p] = {{32{val[VAL_W-1]}}, val};
				while (p > 1) begin
					p = p >> 1;
					tree_sums[p] = tree_sums[2*p] + tree_sums[2*p+1];
				end
				return;
			end
			queries++;
			acc = '0;
			if (lo_pos > hi_pos || int'(lo_pos) >= ELEMS) begin
				empty_queries++;
			end else begin
				hi_c = (int'(hi_pos) >= ELEMS) ? TOP : hi_pos;
				l = lo_pos + ELEMS;
				r = hi_c + ELEMS + 1;
				// standard bottom-up walk over half-open [l, r)
				while (l < r) begin
					if (l[0]) begin
						acc += tree_sums[l];
						l++;
					end
					if (r[0]) begin
						r--;
						acc += tree_sums[r];
					end
					l = l >> 1;
					r = r >> 1;
				end
			end
			pending_totals.push_back(acc[SUM_W-1:0]);
		endfunction

		function void check_total(input sum_t got);
			sum_t want;
			if (pending_totals.size() == 0) begin
				$error("range_total transfer with no query pending: got %0d", $signed(got));
				errors++;
				return;
			end
			want = pending_totals.pop_front();
			totals_checked++;
			if (got !== want) begin
				$error("range_total mismatch: expected %0d, actual %0d",
					$signed(want), $signed(got));
				errors++;
			end
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic                     req_type;
	logic [IDX_W-1:0]         elem_index;
	logic signed [VAL_W-1:0]  elem_value;
	logic [IDX_W-1:0]         range_start;
	logic [IDX_W-1:0]         range_end;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [SUM_W-1:0]  range_total;

	range_sum_scoreboard sb;
	bit quiet;

	range_sum_point_update_tree #(
		.NUM_ELEMS(ELEMS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.elem_index (elem_index),
		.elem_value (elem_value),
		.range_start(range_start),
		.range_end  (range_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.range_total(range_total)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_request(req_type, elem_index, elem_value, range_start, range_end);
		if (arst_n && out_valid && out_ready)
			sb.check_total(range_total);
	end

	// result side: random bursts of stall and accept
	initial begin
		int unsigned n;
		bit          stall;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			n = $urandom_range(1, 8);
			stall = !quiet && ($urandom_range(0, 2) == 0);
			repeat (n) begin
				@(posedge clk);
				out_ready <= !stall;
			end
		end
	end

	initial begin
		#2000000;
		$display("range_sum_point_update_tree test failed");
		$finish;
	end

	task automatic sender_pause();
		int unsigned n;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_item(input req_kind_t kind, input logic [IDX_W-1:0] idx,
		input logic [VAL_W-1:0] val, input logic [IDX_W-1:0] lo_pos,
		input logic [IDX_W-1:0] hi_pos);
		sender_pause();
		in_valid    <= 1'b1;
		req_type    <= kind;
		elem_index  <= idx;
		elem_value  <= val;
		range_start <= lo_pos;
		range_end   <= hi_pos;
		do @(posedge clk); while (!in_ready);
	endtask

	// hold off new transfers until every pending total has come back
	task automatic drain_totals();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_totals.size() != 0);
	endtask

	task automatic send_write(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
		send_item(REQ_WRITE, idx, val, IDX_W'($urandom()), IDX_W'($urandom()));
	endtask

	task automatic send_query(input logic [IDX_W-1:0] lo_pos, input logic [IDX_W-1:0] hi_pos);
		send_item(REQ_QUERY, IDX_W'($urandom()), VAL_W'($urandom()), lo_pos, hi_pos);
	endtask

	function automatic logic [IDX_W-1:0] pick_index();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return IDX_W'(TOP);
			default: return IDX_W'($urandom_range(0, TOP));
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		int                 i;
		int                 t;
		int unsigned        a;
		int unsigned        b;
		logic [IDX_W-1:0]   lo_pos;
		logic [IDX_W-1:0]   hi_pos;

		sb          = new();
		quiet       = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		req_type    = REQ_WRITE;
		elem_index  = '0;
		elem_value  = '0;
		range_start = '0;
		range_end   = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty tree, extreme values at both ends, empty ranges, overwrite
		send_query(IDX_W'(0), IDX_W'(TOP));
		send_write(IDX_W'(0), 32'h7fff_ffff);
		send_write(IDX_W'(TOP), 32'h8000_0000);
		send_write(IDX_W'(512), 32'hffff_ffff);
		send_write(IDX_W'(511), 32'h7fff_ffff);
		send_query(IDX_W'(0), IDX_W'(TOP));
		send_query(IDX_W'(TOP), IDX_W'(TOP));
		send_query(IDX_W'(0), IDX_W'(0));
		send_query(IDX_W'(TOP), IDX_W'(0));
		send_query(IDX_W'(5), IDX_W'(4));
		send_query(IDX_W'(511), IDX_W'(512));
		send_query(IDX_W'(1), IDX_W'(TOP - 1));
		send_write(IDX_W'(0), 32'h0000_0000);
		send_query(IDX_W'(0), IDX_W'(TOP));
		send_write(IDX_W'(1), 32'h5555_5555);
		send_write(IDX_W'(TOP - 1), 32'haaaa_aaaa);
		send_query(IDX_W'(0), IDX_W'(1));
		send_query(IDX_W'(TOP - 1), IDX_W'(TOP));
		send_query(IDX_W'(0), IDX_W'(TOP));
		drain_totals();

		for (i = 0; i < 800; i++) begin
			quiet = (i >= 650);
			if (i == 400)
				drain_totals();
			if ($urandom_range(0, 1) == 0) begin
				send_write(pick_index(), pick_value());
			end else begin
				case ($urandom_range(0, 7))
					0: begin
						a = $urandom_range(1, TOP);
						lo_pos = IDX_W'(a);
						hi_pos = IDX_W'($urandom_range(0, a - 1));
					end
					1: begin
						lo_pos = '0;
						hi_pos = IDX_W'(TOP);
					end
					2: begin
						lo_pos = IDX_W'($urandom_range(0, TOP));
						hi_pos = IDX_W'(TOP);
					end
					3: begin
						lo_pos = '0;
						hi_pos = IDX_W'($urandom_range(0, TOP));
					end
					4, 5: begin
						a = $urandom_range(0, TOP);
						b = a + $urandom_range(0, 15);
						lo_pos = IDX_W'(a);
						hi_pos = IDX_W'((b > TOP) ? TOP : b);
					end
					default: begin
						a = $urandom_range(0, TOP);
						b = $urandom_range(0, TOP);
						lo_pos = IDX_W'((a < b) ? a : b);
						hi_pos = IDX_W'((a < b) ? b : a);
					end
				endcase
				send_query(lo_pos, hi_pos);
			end
		end

		in_valid <= 1'b0;
		for (t = 0; t < 4000 && sb.pending_totals.size() != 0; t++)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.pending_totals.size() != 0) begin
			$error("%0d range totals never arrived", sb.pending_totals.size());
			sb.errors += sb.pending_totals.size();
		end

		$display("Covered %0d element writes and %0d range queries (%0d empty or reversed),",
			sb.writes, sb.queries, sb.empty_queries);
		$display("with %0d totals compared and %0d errors.", sb.totals_checked, sb.errors);
		if (sb.errors == 0)
			$display("range_sum_point_update_tree test passed");
		else
			$display("range_sum_point_update_tree test failed");
		$finish;
	end

endmodule
